// ===== design/assert_macros.svh =====
// Assertion macros used by the RTL of the sorted list similarity block.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/jsls_pkg.sv =====
// Package for the sorted list similarity block: transaction types, mode codes
// and default sizes. No dependencies.
package jsls_pkg;

	localparam int MAX_LIST_DEF = 1024;
	localparam int ID_BITS_DEF  = 20;

	// The similarity is a Q0.16 fraction; the quotient needs one more bit
	// so that exactly 1.0 can be represented.
	localparam int FRAC_BITS = 16;
	localparam int Q_BITS    = FRAC_BITS + 1;

	localparam logic [1:0] MODE_FIRST  = 2'd0;
	localparam logic [1:0] MODE_SECOND = 2'd1;
	localparam logic [1:0] MODE_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [19:0] user_id;
	} req_t;

	typedef struct packed {
		logic [10:0] common_count;
		logic [11:0] union_count;
		logic [16:0] similarity;
		logic        overflow;
	} rsp_t;

endpackage

// ===== design/jaccard_sorted_list_similarity.sv =====
// Top level of the sorted list similarity block: list memories, merge walker,
// restoring divider and result register. Depends on jsls_pkg and assert_macros.svh.
// Usage:
// The request channel (req_valid, req_stall, req) carries one transaction per
// item. Mode first appends req.user_id to the first list, mode second appends it
// to the second list, and mode finish closes the pair. Any other mode is dropped
// without effect. Appends do not stall the channel and never produce a response.
// A finish transaction walks both lists with a two-pointer merge, one comparison per
// cycle, out of two list memories with one write port and one registered read port each.
// The walk ends when either list is exhausted; a restoring divider then computes the Q0.16
// ratio (skipped when nothing matched), and a final step loads the response register
// and raises rsp_valid once that register is free.
// While a finish is being worked on, req_stall is high. The response sits in an
// output register, so appends for the next pair are accepted while it waits.
// If the receiver holds rsp_stall, the response holds, and a following finish
// waits in its last step until the register frees up.
// Appends beyond MAX_LIST entries are dropped and flagged in the next response.
// Reset clears both counts, the drop flag, the control state and rsp_valid.
// List memory contents are not cleared; only written entries are ever read.
module jaccard_sorted_list_similarity
	import jsls_pkg::*;
#(
	parameter int MAX_LIST = MAX_LIST_DEF,
	parameter int ID_BITS  = ID_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	`include "assert_macros.svh"

	// Address width of the list memories and width of counts/pointers,
	// which must be able to hold MAX_LIST itself.
	localparam int AW = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
	localparam int CW = $clog2(MAX_LIST + 1);
	// Union can reach twice MAX_LIST; the divider remainder needs one bit more.
	localparam int UW = CW + 1;
	localparam int RW = UW + 1;
	localparam int DW = $clog2(Q_BITS);

	localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_LIST);
	localparam logic [DW-1:0] DIV_LAST = DW'(Q_BITS - 1);

	// Controller states.
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MERGE = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;

	// List memories and their registered read data.
	logic [ID_BITS-1:0] first_mem  [MAX_LIST];
	logic [ID_BITS-1:0] second_mem [MAX_LIST];
	logic [ID_BITS-1:0] first_rd_q;
	logic [ID_BITS-1:0] second_rd_q;

	logic [CW-1:0] first_cnt_q;
	logic [CW-1:0] second_cnt_q;
	logic          drop_q;

	// Merge pointers and match count.
	logic [CW-1:0] a_q;
	logic [CW-1:0] b_q;
	logic [CW-1:0] hits_q;
	logic [CW-1:0] a_nx;
	logic [CW-1:0] b_nx;

	// Divider state.
	logic [UW-1:0]     uni_q;
	logic [RW-1:0]     rem_q;
	logic [Q_BITS-1:0] quo_q;
	logic [DW-1:0]     div_cnt_q;
	logic [RW-1:0]     trial;
	logic              trial_ge;

	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              req_acc;
	logic              fin_acc;
	logic              merge_live;
	logic              ids_equal;
	logic              first_gt;
	logic              rsp_free;
	logic [ID_BITS-1:0] id_in;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign fin_acc   = req_acc && (req.mode == MODE_FINISH);
	assign id_in     = ID_BITS'(req.user_id);

	// The read data registered last cycle belongs to the current pointers.
	assign merge_live = (state_q == ST_MERGE) && (a_q < first_cnt_q) && (b_q < second_cnt_q);
	assign ids_equal  = (first_rd_q == second_rd_q);
	assign first_gt   = (first_rd_q > second_rd_q);

	// Next pointer values drive the memory read addresses, so one comparison
	// completes every cycle.
	always_comb begin
		a_nx = a_q;
		b_nx = b_q;
		if (fin_acc) begin
			a_nx = '0;
			b_nx = '0;
		end else if (merge_live) begin
			if (ids_equal) begin
				a_nx = a_q + 1'b1;
				b_nx = b_q + 1'b1;
			end else if (first_gt) begin
				b_nx = b_q + 1'b1;
			end else begin
				a_nx = a_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && (req.mode == MODE_FIRST) && (first_cnt_q < MAX_CNT)) begin
			first_mem[first_cnt_q[AW-1:0]] <= id_in;
		end
		if (req_acc && (req.mode == MODE_SECOND) && (second_cnt_q < MAX_CNT)) begin
			second_mem[second_cnt_q[AW-1:0]] <= id_in;
		end
		first_rd_q  <= first_mem[a_nx[AW-1:0]];
		second_rd_q <= second_mem[b_nx[AW-1:0]];
	end

	// Restoring division step: the first step compares the match count itself,
	// giving the integer bit of the quotient; later steps shift in a zero.
	assign trial    = (div_cnt_q == '0) ? rem_q : {rem_q[RW-2:0], 1'b0};
	assign trial_ge = (trial >= RW'(uni_q));
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			drop_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						priority if (req.mode == MODE_FIRST) begin
							if (first_cnt_q < MAX_CNT) begin
								first_cnt_q <= first_cnt_q + 1'b1;
							end else begin
								drop_q <= 1'b1;
							end
						end else if (req.mode == MODE_SECOND) begin
							if (second_cnt_q < MAX_CNT) begin
								second_cnt_q <= second_cnt_q + 1'b1;
							end else begin
								drop_q <= 1'b1;
							end
						end else if (req.mode == MODE_FINISH) begin
							state_q <= ST_MERGE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_MERGE: begin
					if (!merge_live) begin
						state_q <= (hits_q == '0) ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						first_cnt_q  <= '0;
						second_cnt_q <= '0;
						drop_q       <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the merge and the divider.
	always_ff @(posedge clk) begin
		a_q <= a_nx;
		b_q <= b_nx;
		if (fin_acc) begin
			hits_q <= '0;
		end else if (merge_live && ids_equal) begin
			hits_q <= hits_q + 1'b1;
		end
		if ((state_q == ST_MERGE) && !merge_live) begin
			uni_q     <= UW'(first_cnt_q) + UW'(second_cnt_q) - UW'(hits_q);
			rem_q     <= RW'(hits_q);
			quo_q     <= '0;
			div_cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q     <= trial_ge ? (trial - RW'(uni_q)) : trial;
			quo_q     <= {quo_q[Q_BITS-2:0], trial_ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if ((state_q == ST_DONE) && rsp_free) begin
			rsp_q.common_count <= 11'(hits_q);
			rsp_q.union_count  <= 12'(uni_q);
			rsp_q.similarity   <= (hits_q == '0) ? '0 : 17'(quo_q);
			rsp_q.overflow     <= drop_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The merge pointers never run past the list lengths.
	`ASSERT_SAME(a_ptr_in_range, clk, arst_n, state_q == ST_MERGE,
		(a_q <= first_cnt_q) && (b_q <= second_cnt_q), "merge pointer past list end")
	// Every match advances both pointers, so the count trails each of them.
	`ASSERT_SAME(hits_bounded, clk, arst_n, state_q == ST_MERGE,
		(hits_q <= a_q) && (hits_q <= b_q), "match count exceeds a pointer")
	// The partial remainder stays at or below the divisor.
	`ASSERT_SAME(rem_bounded, clk, arst_n, state_q == ST_DIV,
		rem_q <= RW'(uni_q), "divider remainder above divisor")
	// A new response only comes from the final step.
	`ASSERT_NEXT(rsp_from_done, clk, arst_n, !rsp_valid_q,
		!rsp_valid_q || ($past(state_q) == ST_DONE), "response without finish")

endmodule
